@@ rtl/core/comment_aware_word_count_assert.svh @@
// Assertion macros for the port checker of the word counter.
// Each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef COMMENT_AWARE_WORD_COUNT_ASSERT_SVH
`define COMMENT_AWARE_WORD_COUNT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word counter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAWC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word counter assertion failed");

`endif

@@ rtl/core/cawc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cawc_pkg;

    // Counter width and the width of the reported totals.
    localparam int COUNT_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int EXT_WIDTH   = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [OUT_WIDTH-1:0]   total_t;

    localparam count_t CNT_MAX  = '1;
    localparam count_t CNT_ZERO = '0;
    localparam count_t CNT_ONE  = count_t'(1);

    // Characters the scanner looks for.
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Scanner states.
    typedef enum logic [2:0] {
        ST_OUT,   // outside a word
        ST_IN,    // inside a word
        ST_SLW,   // slash seen inside a word
        ST_SLN,   // slash that began a new word
        ST_COM,   // inside a comment
        ST_STAR,  // star seen inside a comment
        ST_END    // comment just closed
    } scan_state_t;

    // Input operation codes.
    typedef enum logic {
        OP_BYTE   = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    // One report transaction.
    typedef struct packed {
        total_t line_total;
        total_t word_total;
        total_t char_total;
        logic   unterminated;
        total_t error_line;
    } report_t;

    // Saturating increment: the maximum is sticky.
    function automatic count_t sat_inc(count_t v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    // Saturating take-back: a counter at the maximum or at zero is left alone.
    function automatic count_t sat_dec(count_t v);
        return ((v == CNT_MAX) || (v == CNT_ZERO)) ? v : v - CNT_ONE;
    endfunction

    // Whitespace is tab through carriage return, and space.
    function automatic logic is_space(logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    // Low bits of a counter, zero-extended when the counter is narrower.
    function automatic total_t to_total(count_t v);
        logic [EXT_WIDTH-1:0] x;
        x = EXT_WIDTH'(v);
        return x[OUT_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cawc_text_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Text channel: one byte or an end-of-text marker per transaction.
interface cawc_text_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] text_byte;

    modport source (output valid, output operation, output text_byte, input ready);
    modport sink   (input valid, input operation, input text_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cawc_report_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Report channel: the totals for one text per transaction.
interface cawc_report_if;
    logic              valid;
    logic              ready;
    cawc_pkg::total_t  line_total;
    cawc_pkg::total_t  word_total;
    cawc_pkg::total_t  char_total;
    logic              unterminated;
    cawc_pkg::total_t  error_line;

    modport source (output valid, output line_total, output word_total, output char_total,
                    output unterminated, output error_line, input ready);
    modport sink   (input valid, input line_total, input word_total, input char_total,
                    input unterminated, input error_line, output ready);
endinterface

`default_nettype wire

@@ rtl/core/comment_aware_word_count.sv @@
// An end-of-text transaction passes through the input register, then the result register,
// from which its report is taken. Throughput: one transaction per cycle; an end-of-text
// transaction waits only while the result register holds a report that is not taken.
// Reset: rst_n clears the counts to line one, no words, no characters, and empties
// both registers; no report is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module comment_aware_word_count (
    input  logic          clk,
    input  logic          rst_n,
    cawc_text_if.sink     text,
    cawc_report_if.source report
);
    import cawc_pkg::*;

    logic    rep_valid;
    logic    rep_ready;
    report_t rep_data;

    // Scanner with its input register and counters.
    cawc_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .rep_valid (rep_valid),
        .rep_ready (rep_ready),
        .rep_data  (rep_data)
    );

    // Output register toward the report channel.
    cawc_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .rep_valid (rep_valid),
        .rep_ready (rep_ready),
        .rep_data  (rep_data),
        .report    (report)
    );

endmodule

`default_nettype wire

@@ rtl/core/cawc_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input register, scanner state machine and the saturating counters.
module cawc_scanner (
    input  logic              clk,
    input  logic              rst_n,
    cawc_text_if.sink         text,
    output logic              rep_valid,
    input  logic              rep_ready,
    output cawc_pkg::report_t rep_data
);
    import cawc_pkg::*;

    logic        stage_valid_reg, stage_valid_next;
    logic        stage_op_reg;
    logic [7:0]  stage_byte_reg;
    logic        advance;
    logic        open_comment;

    scan_state_t state_reg, state_next;
    count_t      line_reg, line_next;
    count_t      word_reg, word_next;
    count_t      char_reg, char_next;
    count_t      start_reg, start_next;

    // A byte always retires; a finish waits until the result register can take it.
    assign advance   = stage_valid_reg && ((stage_op_reg == OP_BYTE) || rep_ready);
    assign text.ready = !stage_valid_reg || advance;
    assign stage_valid_next = text.valid ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Input register payload, loaded on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            stage_op_reg   <= text.operation;
            stage_byte_reg <= text.text_byte;
        end
    end

    // Report built from the current counts.
    assign open_comment = (state_reg == ST_COM) || (state_reg == ST_STAR);
    assign rep_valid    = stage_valid_reg && (stage_op_reg == OP_FINISH);

    always_comb
    begin
        rep_data.line_total   = (char_reg == CNT_ZERO) ? '0 : to_total(line_reg);
        rep_data.word_total   = to_total(word_reg);
        rep_data.char_total   = to_total(char_reg);
        rep_data.unterminated = open_comment;
        rep_data.error_line   = open_comment ? to_total(start_reg) : '0;
    end

    // Next state and counter updates for the item in the input register.
    always_comb
    begin
        state_next = state_reg;
        line_next  = line_reg;
        word_next  = word_reg;
        char_next  = char_reg;
        start_next = start_reg;

        if (advance)
        begin
            if (stage_op_reg == OP_FINISH)
            begin
                // The report leaves now; return to the reset values.
                state_next = ST_OUT;
                line_next  = CNT_ONE;
                word_next  = CNT_ZERO;
                char_next  = CNT_ZERO;
                start_next = CNT_ONE;
            end
            else
            begin
                unique case (state_reg) inside
                    ST_IN:
                    begin
                        if (is_space(stage_byte_reg))
                        begin
                            if (stage_byte_reg == CH_NEWLINE)
                            begin
                                line_next = sat_inc(line_reg);
                            end
                            char_next  = sat_inc(char_reg);
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            char_next = sat_inc(char_reg);
                            if (stage_byte_reg == CH_SLASH)
                            begin
                                state_next = ST_SLW;
                            end
                        end
                    end
                    ST_SLW, ST_SLN:
                    begin
                        if (is_space(stage_byte_reg))
                        begin
                            if (stage_byte_reg == CH_NEWLINE)
                            begin
                                line_next = sat_inc(line_reg);
                            end
                            char_next  = sat_inc(char_reg);
                            state_next = ST_OUT;
                        end
                        else if (stage_byte_reg == CH_STAR)
                        begin
                            // The slash opened a comment: take it back.
                            char_next = sat_dec(char_reg);
                            if (state_reg == ST_SLN)
                            begin
                                word_next = sat_dec(word_reg);
                            end
                            start_next = line_reg;
                            state_next = ST_COM;
                        end
                        else
                        begin
                            char_next = sat_inc(char_reg);
                            if (stage_byte_reg != CH_SLASH)
                            begin
                                state_next = ST_IN;
                            end
                        end
                    end
                    ST_COM:
                    begin
                        if (stage_byte_reg == CH_STAR)
                        begin
                            state_next = ST_STAR;
                        end
                        else if (stage_byte_reg == CH_NEWLINE)
                        begin
                            line_next = sat_inc(line_reg);
                            char_next = sat_inc(char_reg);
                        end
                    end
                    ST_STAR:
                    begin
                        if (stage_byte_reg == CH_SLASH)
                        begin
                            // The closed comment counts as one character.
                            char_next  = sat_inc(char_reg);
                            state_next = ST_END;
                        end
                        else if (stage_byte_reg != CH_STAR)
                        begin
                            if (stage_byte_reg == CH_NEWLINE)
                            begin
                                line_next = sat_inc(line_reg);
                                char_next = sat_inc(char_reg);
                            end
                            state_next = ST_COM;
                        end
                    end
                    default:
                    begin
                        // Outside a word, just after a comment, or the unused code.
                        if (is_space(stage_byte_reg))
                        begin
                            if (stage_byte_reg == CH_NEWLINE)
                            begin
                                line_next = sat_inc(line_reg);
                            end
                            char_next  = sat_inc(char_reg);
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            word_next  = sat_inc(word_reg);
                            char_next  = sat_inc(char_reg);
                            state_next = (stage_byte_reg == CH_SLASH) ? ST_SLN : ST_IN;
                        end
                    end
                endcase
            end
        end
    end

    // Scanner state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_OUT;
            line_reg  <= CNT_ONE;
            word_reg  <= CNT_ZERO;
            char_reg  <= CNT_ZERO;
            start_reg <= CNT_ONE;
        end
        else
        begin
            state_reg <= state_next;
            line_reg  <= line_next;
            word_reg  <= word_next;
            char_reg  <= char_next;
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cawc_result.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Result register that holds a report until the sink takes it.
module cawc_result (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rep_valid,
    output logic              rep_ready,
    input  cawc_pkg::report_t rep_data,
    cawc_report_if.source     report
);
    import cawc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    report_t out_data_reg;
    logic    load;

    // The register takes a new report when it is empty or being drained.
    assign rep_ready = !out_valid_reg || report.ready;
    assign load      = rep_valid && rep_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= rep_data;
        end
    end

    // Drive the report channel from the register.
    assign report.valid        = out_valid_reg;
    assign report.line_total   = out_data_reg.line_total;
    assign report.word_total   = out_data_reg.word_total;
    assign report.char_total   = out_data_reg.char_total;
    assign report.unterminated = out_data_reg.unterminated;
    assign report.error_line   = out_data_reg.error_line;

endmodule

`default_nettype wire

@@ rtl/core/cawc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "comment_aware_word_count_assert.svh"

// Checks on the port behavior of the word counter.
module cawc_port_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             text_valid,
    input logic             text_ready,
    input logic             text_operation,
    input logic             report_valid,
    input logic             report_ready,
    input cawc_pkg::total_t line_total,
    input cawc_pkg::total_t word_total,
    input cawc_pkg::total_t char_total,
    input logic             unterminated,
    input cawc_pkg::total_t error_line
);
    import cawc_pkg::*;

    logic                  stalled;
    logic [4*OUT_WIDTH:0]  totals;
    logic                  finish_taken;
    logic                  empty_ok;
    logic                  closed_ok;

    assign stalled      = report_valid && !report_ready;
    assign totals       = {line_total, word_total, char_total, unterminated, error_line};
    assign finish_taken = text_valid && text_ready && (text_operation == OP_FINISH);
    assign empty_ok     = (char_total != '0) || (line_total == '0);
    assign closed_ok    = unterminated || (error_line == '0);

    // A stalled report holds its totals.
    `CAWC_ASSERT_NXT(a_report_hold, clk, rst_n, stalled, report_valid && $stable(totals))

    // A fresh report follows an end-of-text transaction through the input and result registers.
    `CAWC_ASSERT_IMP(a_report_source, clk, rst_n, $rose(report_valid), $past(finish_taken, 2))

    // With no report waiting, the text channel is never stalled.
    `CAWC_ASSERT_IMP(a_text_ready, clk, rst_n, !report_valid, text_ready)

    // Empty text reports no lines, and a closed text reports no error line.
    `CAWC_ASSERT_IMP(a_report_zero, clk, rst_n, report_valid, empty_ok && closed_ok)

endmodule

bind comment_aware_word_count cawc_port_checker u_cawc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_valid     (text.valid),
    .text_ready     (text.ready),
    .text_operation (text.operation),
    .report_valid   (report.valid),
    .report_ready   (report.ready),
    .line_total     (report.line_total),
    .word_total     (report.word_total),
    .char_total     (report.char_total),
    .unterminated   (report.unterminated),
    .error_line     (report.error_line)
);

`default_nettype wire

@@ tb/sv/cawc_checker.sv @@
`timescale 1ns / 1ps

// Watches the text and report channels. It keeps its own copy of the counter
// state, works out the report that each end-of-text transaction must produce,
// and compares every report transaction with the oldest one still due.
module cawc_checker (
    input  logic          clk,
    input  logic          rst_n,
    cawc_text_if          text,
    cawc_report_if        report,
    output int            fail_count,
    output int            reports_due
);
    import cawc_pkg::*;

    // Shadow copy of the scanner and its counters.
    scan_state_t scan;
    count_t      lines;
    count_t      words;
    count_t      chars;
    count_t      open_line;

    report_t     due_reports[$];
    int          mismatches = 0;

    // Counters stop at all ones and then stay there.
    function automatic count_t bump(count_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // A take-back leaves a saturated counter and a zero counter unchanged.
    function automatic count_t take_back(count_t v);
        return ((&v) || (v == '0)) ? v : v - 1'b1;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == CH_SPACE);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_counts();
        scan      = ST_OUT;
        lines     = count_t'(1);
        words     = '0;
        chars     = '0;
        open_line = count_t'(1);
    endtask

    // Whitespace outside a comment counts as a character, a newline also as a line.
    task automatic count_blank(input logic [7:0] c);
        if (c == CH_NEWLINE)
            lines = bump(lines);
        chars = bump(chars);
    endtask

    // Advance the scanner by one text byte.
    task automatic scan_byte(input logic [7:0] c);
        case (scan)
            ST_IN:
            begin
                if (is_blank(c))
                begin
                    count_blank(c);
                    scan = ST_OUT;
                end
                else
                begin
                    chars = bump(chars);
                    if (c == CH_SLASH)
                        scan = ST_SLW;
                end
            end
            ST_SLW, ST_SLN:
            begin
                if (is_blank(c))
                begin
                    count_blank(c);
                    scan = ST_OUT;
                end
                else if (c == CH_STAR)
                begin
                    // The slash opened a comment: it was no character, and no word
                    // either when it stood at the start of one.
                    chars = take_back(chars);
                    if (scan == ST_SLN)
                        words = take_back(words);
                    open_line = lines;
                    scan = ST_COM;
                end
                else
                begin
                    chars = bump(chars);
                    if (c != CH_SLASH)
                        scan = ST_IN;
                end
            end
            ST_COM:
            begin
                if (c == CH_STAR)
                    scan = ST_STAR;
                else if (c == CH_NEWLINE)
                begin
                    lines = bump(lines);
                    chars = bump(chars);
                end
            end
            ST_STAR:
            begin
                if (c == CH_SLASH)
                begin
                    // The closed comment counts as a single character.
                    chars = bump(chars);
                    scan = ST_END;
                end
                else if (c != CH_STAR)
                begin
                    if (c == CH_NEWLINE)
                    begin
                        lines = bump(lines);
                        chars = bump(chars);
                    end
                    scan = ST_COM;
                end
            end
            default:
            begin
                // Outside a word, or right after a comment.
                if (is_blank(c))
                begin
                    count_blank(c);
                    scan = ST_OUT;
                end
                else
                begin
                    words = bump(words);
                    chars = bump(chars);
                    scan = (c == CH_SLASH) ? ST_SLN : ST_IN;
                end
            end
        endcase
    endtask

    // A text byte advances the scanner; an end-of-text transaction queues the report and clears the counts.
    task automatic take_item(input op_t op, input logic [7:0] c);
        report_t r;
        logic    still_open;
        if (op == OP_FINISH)
        begin
            still_open     = (scan == ST_COM) || (scan == ST_STAR);
            r.line_total   = (chars == '0) ? '0 : total_t'(lines);
            r.word_total   = total_t'(words);
            r.char_total   = total_t'(chars);
            r.unterminated = still_open;
            r.error_line   = still_open ? total_t'(open_line) : '0;
            due_reports.push_back(r);
            clear_counts();
        end
        else
            scan_byte(c);
    endtask

    task automatic check_report();
        report_t want;
        if (due_reports.size() == 0)
            report_mismatch("report with no text pending", report.line_total, 32'd0);
        else
        begin
            want = due_reports.pop_front();
            if (report.line_total !== want.line_total)
                report_mismatch("line_total", report.line_total, want.line_total);
            if (report.word_total !== want.word_total)
                report_mismatch("word_total", report.word_total, want.word_total);
            if (report.char_total !== want.char_total)
                report_mismatch("char_total", report.char_total, want.char_total);
            if (report.unterminated !== want.unterminated)
                report_mismatch("unterminated", 32'(report.unterminated),
                                32'(want.unterminated));
            if (report.error_line !== want.error_line)
                report_mismatch("error_line", report.error_line, want.error_line);
        end
    endtask

    // Sample both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_counts();
            due_reports.delete();
            reports_due <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (report.valid && report.ready)
                check_report();
            if (text.valid && text.ready)
                take_item(op_t'(text.operation), text.text_byte);
            reports_due <= due_reports.size();
            fail_count  <= mismatches;
        end
    end

endmodule

@@ tb/sv/tb_comment_aware_word_count.sv @@
`timescale 1ns / 1ps

module tb_comment_aware_word_count;
    import cawc_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    logic clk;
    logic rst_n;

    cawc_text_if   text();
    cawc_report_if report();

    int fail_count;
    int reports_due;
    int idle_pct;
    int stall_pct;
    int holds_asked;
    int items_sent;
    int quiet_cycles = 0;

    comment_aware_word_count u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .report (report)
    );

    cawc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .text        (text),
        .report      (report),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    // 125 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Report side: random stalls, plus a long hold-off whenever one is asked for.
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        report.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                report.ready <= 1'b0;
            end
            else
                report.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // End the run when no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((text.valid && text.ready) || (report.valid && report.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one transaction, after a random idle gap, and wait until it is taken.
    task automatic send_item(input op_t op, input logic [7:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            text.valid <= 1'b0;
            @(posedge clk);
        end
        text.valid     <= 1'b1;
        text.operation <= op;
        text.text_byte <= c;
        @(posedge clk);
        while (!text.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_BYTE, s[i]);
    endtask

    // One text built from words, whitespace, block comments (now and then left
    // open), stray slashes and stars, and arbitrary bytes, then the end marker.
    task automatic send_random_text();
        int         kind;
        int         n;
        logic [7:0] c;
        repeat ($urandom_range(1, 10))
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(OP_BYTE, 8'($urandom_range(33, 126)));
            end
            else if (kind < 55)
            begin
                n = $urandom_range(5);
                send_item(OP_BYTE, (n == 5) ? CH_SPACE : 8'(9 + n));
            end
            else if (kind < 80)
            begin
                send_item(OP_BYTE, CH_SLASH);
                send_item(OP_BYTE, CH_STAR);
                repeat ($urandom_range(0, 6))
                begin
                    n = $urandom_range(9);
                    if (n < 2)
                        c = CH_NEWLINE;
                    else if (n < 4)
                        c = CH_STAR;
                    else if (n == 4)
                        c = CH_SLASH;
                    else if (n == 5)
                        c = CH_SPACE;
                    else
                        c = 8'($urandom_range(33, 126));
                    send_item(OP_BYTE, c);
                end
                if ($urandom_range(9) != 0)
                begin
                    repeat ($urandom_range(1, 3))
                        send_item(OP_BYTE, CH_STAR);
                    send_item(OP_BYTE, CH_SLASH);
                end
            end
            else if (kind < 92)
            begin
                repeat ($urandom_range(1, 3))
                    send_item(OP_BYTE, ($urandom_range(1) != 0) ? CH_SLASH : CH_STAR);
            end
            else
                send_item(OP_BYTE, 8'($urandom_range(255)));
        end
        send_item(OP_FINISH, 8'($urandom_range(255)));
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n          <= 1'b0;
        text.valid     <= 1'b0;
        text.operation <= OP_BYTE;
        text.text_byte <= '0;
        stall_pct      <= 0;
        holds_asked    <= 0;
        idle_pct        = 0;
        items_sent      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty text: no characters, so the line count reads zero.
        send_item(OP_FINISH, 8'hFF);
        // Extreme bytes, all whitespace kinds, a comment opened by a word-starting
        // slash with a newline and a double star inside, then a word whose slash
        // opens a comment that is never closed.
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_text("\t\013\014\015 /*\n**/x/*");
        send_item(OP_FINISH, 8'h00);
        // Double slash starting a word, then a comment taking that word back.
        send_text("//**/");
        send_item(OP_FINISH, 8'h5A);

        // Random texts under each idling pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 85;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 85;
                end
                default:
                begin
                    idle_pct = 14;
                    stall_pct <= 14;
                end
            endcase
            items_sent = 0;
            while (items_sent < RANDOM_ITEMS / 4)
                send_random_text();

            // Back-pressure: hold the report side off while short texts keep
            // coming, so the block fills up and stops taking input.
            if (phase == 0)
            begin
                holds_asked <= holds_asked + 1;
                repeat (12)
                begin
                    send_item(OP_BYTE, 8'h61);
                    send_item(OP_BYTE, CH_NEWLINE);
                    send_item(OP_FINISH, 8'h00);
                end
            end
        end
        text.valid <= 1'b0;

        // Drain the outstanding reports, then allow for the pipeline.
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && reports_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
